// ===== hdl/bpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and constants of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int IDX_W      = 17;
    localparam int FIFO_DEPTH = 2;
    localparam int WORD_BITS  = 64;

    localparam logic [31:0] KERNEL_HEAP_START = 32'hc010_0000;
    localparam logic [31:0] USER_VIRT_RESET   = 32'h0804_8000;
    localparam logic [31:0] KERNEL_PHYS_RESET = 32'h0020_0000;
    localparam logic [31:0] USER_PHYS_RESET   = 32'h0120_0000;
    localparam logic [12:0] POOL_PAGES_RESET  = 13'd4096;

    localparam logic [2:0] CFG_KERNEL_VIRT_BASE = 3'd0;
    localparam logic [2:0] CFG_USER_VIRT_BASE   = 3'd1;
    localparam logic [2:0] CFG_KERNEL_PHYS_BASE = 3'd2;
    localparam logic [2:0] CFG_USER_PHYS_BASE   = 3'd3;
    localparam logic [2:0] CFG_KERNEL_PAGES     = 3'd4;
    localparam logic [2:0] CFG_USER_PAGES       = 3'd5;

    localparam logic [1:0] FUNC_ALLOC     = 2'd0;
    localparam logic [1:0] FUNC_FREE_VIRT = 2'd1;
    localparam logic [1:0] FUNC_FREE_PHYS = 2'd2;
    localparam logic [1:0] FUNC_RSVD      = 2'd3;

    localparam logic [1:0] STAT_MAP     = 2'd0;
    localparam logic [1:0] STAT_FREED   = 2'd1;
    localparam logic [1:0] STAT_NO_VIRT = 2'd2;
    localparam logic [1:0] STAT_NO_PHYS = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic        pool;
        logic [6:0]  page_count;
        logic [31:0] virt_addr;
        logic [31:0] phys_addr;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_virt;
        logic [31:0] out_phys;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] kernel_virt_base;
        logic [31:0] user_virt_base;
        logic [31:0] kernel_phys_base;
        logic [31:0] user_phys_base;
        logic [12:0] kernel_pages;
        logic [12:0] user_pages;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_REJECT,
        CMD_FREE
    } cmd_kind_t;

    // for alloc: hi is pool size, res_virt/res_phys are the pool bases
    typedef struct packed {
        cmd_kind_t        kind;
        logic             map_user;
        logic             map_phys;
        logic [6:0]       count;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic             skip;
        logic [31:0]      res_virt;
        logic [31:0]      res_phys;
    } cmd_t;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] count;
    } fifo_stat_t;

    typedef struct packed {
        logic clearing;
        logic idle;
    } back_stat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_WAIT,
        ST_SCAN,
        ST_WR,
        ST_PSET,
        ST_EMIT
    } back_state_t;

    typedef enum logic [1:0] {
        MODE_VSCAN,
        MODE_PSCAN,
        MODE_VMARK,
        MODE_FREE
    } back_mode_t;

endpackage

// ===== hdl/bitmap_page_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page allocator over kernel and user virtual/physical bitmaps.
// ----------------------------------------------------------------------------
// Channel   Ports                      Direction  Content
// request   s_valid s_ready s_item     in         func, pool, count, addresses
// result    m_valid m_ready m_item     out        status, mappings, last
// config    cfg_wr_en cfg_index ...    in         base and size registers
//
// Bitmaps live in one RAM of 64-bit words. A run scan reads and latches a word, then
// checks it in eight 8-bit steps, up to POOL_PAGES/64 words; each physical page
// rescans from the last frame's word; marking reads, latches and rewrites each word.
// After reset a clearing pass zeroes all 4*POOL_PAGES/64 words before any item.
// Frees read, latch and rewrite each touched word; a stalled result holds the back.
// ----------------------------------------------------------------------------
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int POOL_PAGES = 4096,
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_RUN    = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wr_data
);
    cfg_t       cfg_reg, cfg_next;
    fifo_stat_t fifo_stat;
    back_stat_t back_stat;
    cmd_t       push_cmd, head;
    logic       push, pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_KERNEL_VIRT_BASE: cfg_next.kernel_virt_base = cfg_wr_data;
                CFG_USER_VIRT_BASE:   cfg_next.user_virt_base   = cfg_wr_data;
                CFG_KERNEL_PHYS_BASE: cfg_next.kernel_phys_base = cfg_wr_data;
                CFG_USER_PHYS_BASE:   cfg_next.user_phys_base   = cfg_wr_data;
                CFG_KERNEL_PAGES:     cfg_next.kernel_pages     = cfg_wr_data[12:0];
                CFG_USER_PAGES:       cfg_next.user_pages       = cfg_wr_data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{KERNEL_HEAP_START, USER_VIRT_RESET, KERNEL_PHYS_RESET,
                         USER_PHYS_RESET, POOL_PAGES_RESET, POOL_PAGES_RESET};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    bpa_front #(
        .POOL_PAGES(POOL_PAGES),
        .PAGE_BYTES(PAGE_BYTES),
        .MAX_RUN   (MAX_RUN)
    ) u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .cfg      (cfg_reg),
        .fifo_stat(fifo_stat),
        .push     (push),
        .cmd      (push_cmd)
    );

    bpa_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .head    (head),
        .stat    (fifo_stat)
    );

    bpa_back #(
        .POOL_PAGES(POOL_PAGES),
        .PAGE_BYTES(PAGE_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .fifo_stat(fifo_stat),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .stat     (back_stat)
    );

    a_no_result_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.clearing |-> !m_valid)
        else $error("result valid during clearing pass");

    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_stat.count <= 2'(FIFO_DEPTH))
        else $error("command queue overflow");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !fifo_stat.empty && back_stat.idle)
        else $error("pop from empty queue or busy back");
endmodule

// ===== hdl/bpa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hdl/bpa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_front
// Classifies request items and resolves free addresses to bit ranges.
// ----------------------------------------------------------------------------
module bpa_front
    import bpa_pkg::*;
#(
    parameter int POOL_PAGES = 4096,
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_RUN    = 64
) (
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_item,
    input  cfg_t       cfg,
    input  fifo_stat_t fifo_stat,
    output logic       push,
    output cmd_t       cmd
);
    localparam int PS = $clog2(PAGE_BYTES);

    logic [IDX_W-1:0] size_k, size_u, size_sel;
    logic             up;
    logic [31:0]      vbase, pbase, diff, idx;
    logic [32:0]      sum;

    always_comb begin
        size_k = (32'(cfg.kernel_pages) > 32'(POOL_PAGES)) ? IDX_W'(POOL_PAGES)
                                                          : IDX_W'(cfg.kernel_pages);
        size_u = (32'(cfg.user_pages) > 32'(POOL_PAGES)) ? IDX_W'(POOL_PAGES)
                                                        : IDX_W'(cfg.user_pages);
        up     = (s_item.phys_addr >= cfg.user_phys_base);
        vbase  = s_item.pool ? cfg.user_virt_base : cfg.kernel_virt_base;
        pbase  = s_item.pool ? cfg.user_phys_base : cfg.kernel_phys_base;

        cmd          = '0;
        cmd.count    = s_item.page_count;
        cmd.map_user = s_item.pool;
        size_sel     = s_item.pool ? size_u : size_k;
        diff         = s_item.virt_addr - vbase;

        case (s_item.func)
            FUNC_ALLOC: begin
                if (s_item.page_count == 7'd0 || 32'(s_item.page_count) > 32'(MAX_RUN)) begin
                    cmd.kind = CMD_REJECT;
                end else begin
                    cmd.kind = CMD_ALLOC;
                end
                cmd.hi       = size_sel;
                cmd.res_virt = vbase;
                cmd.res_phys = pbase;
            end
            FUNC_FREE_PHYS: begin
                cmd.kind     = CMD_FREE;
                cmd.map_user = up;
                cmd.map_phys = 1'b1;
                size_sel     = up ? size_u : size_k;
                diff         = s_item.phys_addr - (up ? cfg.user_phys_base
                                                      : cfg.kernel_phys_base);
                cmd.res_phys = s_item.phys_addr;
            end
            default: begin
                cmd.kind     = CMD_FREE;
                cmd.res_virt = s_item.virt_addr;
            end
        endcase

        idx = diff >> PS;
        if (s_item.func == FUNC_FREE_PHYS) begin
            sum = 33'(idx) + 33'd1;
        end else begin
            sum = 33'(idx) + 33'(s_item.page_count);
        end
        if (cmd.kind == CMD_FREE) begin
            cmd.skip = (idx >= 32'(size_sel)) || (sum == 33'(idx));
            cmd.lo   = IDX_W'(idx);
            cmd.hi   = (sum > 33'(size_sel)) ? size_sel : IDX_W'(sum);
        end
    end

    assign s_ready = !fifo_stat.full;
    assign push    = s_valid && s_ready && (s_item.func != FUNC_RSVD);
endmodule

// ===== hdl/bpa_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module bpa_fifo
    import bpa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  cmd_t       push_cmd,
    input  logic       pop,
    output cmd_t       head,
    output fifo_stat_t stat
);
    cmd_t       mem_reg [FIFO_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'(FIFO_DEPTH));
    assign stat.empty = (count_reg == 2'd0);
    assign stat.count = count_reg;
endmodule

// ===== hdl/bpa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_back
// Executes commands on the bitmap RAM: run scan, mark, free, emit results.
// ----------------------------------------------------------------------------
module bpa_back
    import bpa_pkg::*;
#(
    parameter int POOL_PAGES = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       head,
    input  fifo_stat_t fifo_stat,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item,
    output back_stat_t stat
);
    localparam int PS    = $clog2(PAGE_BYTES);
    localparam int IW    = $clog2(POOL_PAGES) + 1;
    localparam int DEPTH = POOL_PAGES / WORD_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RD    = 4 * DEPTH;
    localparam int RAW   = $clog2(RD);
    localparam int WS    = $clog2(WORD_BITS);

    back_state_t          state_reg, state_next;
    back_mode_t           mode_reg, mode_next;
    logic [RAW-1:0]       clr_reg, clr_next;
    logic                 user_reg, user_next;
    logic                 phys_reg, phys_next;
    logic [6:0]           count_reg, count_next;
    logic [6:0]           len_reg, len_next;
    logic [6:0]           run_reg, run_next;
    logic [6:0]           page_reg, page_next;
    logic [IW-1:0]        size_reg, size_next;
    logic [IW-1:0]        lo_reg, lo_next;
    logic [IW-1:0]        hi_reg, hi_next;
    logic [AW-1:0]        wa_reg, wa_next;
    logic [2:0]           ch_reg, ch_next;
    logic [WORD_BITS-1:0] buf_reg, buf_next;
    logic [31:0]          va_reg, va_next;
    logic [31:0]          pbase_reg, pbase_next;
    out_item_t            pend_reg, pend_next;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_item_reg, m_item_next;

    logic                 ram_we;
    logic [RAW-1:0]       ram_addr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    logic                 sc_found, sc_stop, sc_end;
    logic [IW-1:0]        sc_pos, base_gi, gi;
    logic [6:0]           sc_run, r;
    logic                 more, room;
    logic [WORD_BITS-1:0] mask;

    bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(RD)) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // eight bits of the current word per cycle
    always_comb begin
        r        = run_reg;
        sc_found = 1'b0;
        sc_stop  = 1'b0;
        sc_pos   = '0;
        gi       = '0;
        base_gi  = (IW'(wa_reg) << WS) + (IW'(ch_reg) << 3);
        for (int j = 0; j < 8; j++) begin
            gi = base_gi + IW'(j);
            if (!sc_found && !sc_stop) begin
                if (gi >= size_reg) begin
                    sc_stop = 1'b1;
                end else begin
                    r = buf_reg[{ch_reg, 3'(j)}] ? 7'd0 : r + 7'd1;
                    if (r == len_reg) begin
                        sc_found = 1'b1;
                        sc_pos   = gi + 1'b1 - IW'(len_reg);
                    end
                end
            end
        end
        sc_run = r;
        sc_end = (ch_reg == 3'd7) && (32'(wa_reg) == DEPTH - 1);
    end

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            mask[b] = ((IW'(wa_reg) << WS) + IW'(b) >= lo_reg)
                   && ((IW'(wa_reg) << WS) + IW'(b) <  hi_reg);
        end
        more = ((IW'(wa_reg) + IW'(1)) << WS) < hi_reg;
        room = !m_valid_reg || m_ready;
    end

    always_comb begin
        case (state_reg)
            ST_CLEAR: state_next = (32'(clr_reg) == RD - 1) ? ST_IDLE : ST_CLEAR;
            ST_IDLE: begin
                if (!fifo_stat.empty) begin
                    if (head.kind == CMD_ALLOC || (head.kind == CMD_FREE && !head.skip)) begin
                        state_next = ST_RD;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:   state_next = ST_WAIT;
            ST_WAIT: begin
                if (mode_reg == MODE_VSCAN || mode_reg == MODE_PSCAN) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_WR;
                end
            end
            ST_SCAN: begin
                if (sc_found) begin
                    state_next = (mode_reg == MODE_VSCAN) ? ST_RD : ST_PSET;
                end else if (sc_stop || sc_end) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = (ch_reg == 3'd7) ? ST_RD : ST_SCAN;
                end
            end
            ST_WR: begin
                if (more || mode_reg == MODE_VMARK) begin
                    state_next = ST_RD;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_PSET: state_next = ST_EMIT;
            ST_EMIT: begin
                if (room) begin
                    state_next = pend_reg.last ? ST_IDLE : ST_RD;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        mode_next    = mode_reg;
        clr_next     = clr_reg;
        user_next    = user_reg;
        phys_next    = phys_reg;
        count_next   = count_reg;
        len_next     = len_reg;
        run_next     = run_reg;
        page_next    = page_reg;
        size_next    = size_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        wa_next      = wa_reg;
        ch_next      = ch_reg;
        buf_next     = buf_reg;
        va_next      = va_reg;
        pbase_next   = pbase_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        pop          = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = RAW'(phys_reg) * RAW'(2 * DEPTH) + RAW'(user_reg) * RAW'(DEPTH)
                     + RAW'(wa_reg);
        ram_wdata    = buf_reg;

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            ST_IDLE: begin
                if (!fifo_stat.empty) begin
                    pop        = 1'b1;
                    user_next  = head.map_user;
                    phys_next  = head.map_phys;
                    count_next = head.count;
                    len_next   = head.count;
                    size_next  = IW'(head.hi);
                    lo_next    = IW'(head.lo);
                    hi_next    = IW'(head.hi);
                    va_next    = head.res_virt;
                    pbase_next = head.res_phys;
                    ch_next    = 3'd0;
                    run_next   = 7'd0;
                    if (head.kind == CMD_ALLOC) begin
                        mode_next = MODE_VSCAN;
                        wa_next   = '0;
                    end else begin
                        mode_next = MODE_FREE;
                        wa_next   = AW'(IW'(head.lo) >> WS);
                    end
                    if (head.kind == CMD_REJECT) begin
                        pend_next = '{STAT_NO_VIRT, 32'd0, 32'd0, 1'b1};
                    end else begin
                        pend_next = '{STAT_FREED, head.res_virt, head.res_phys, 1'b1};
                    end
                end
            end
            ST_WAIT: buf_next = ram_rdata;
            ST_SCAN: begin
                run_next = sc_run;
                if (sc_found) begin
                    lo_next = sc_pos;
                    if (mode_reg == MODE_VSCAN) begin
                        hi_next   = sc_pos + IW'(len_reg);
                        wa_next   = AW'(sc_pos >> WS);
                        mode_next = MODE_VMARK;
                    end
                end else if (sc_stop || sc_end) begin
                    if (mode_reg == MODE_VSCAN) begin
                        pend_next = '{STAT_NO_VIRT, 32'd0, 32'd0, 1'b1};
                    end else begin
                        pend_next = '{STAT_NO_PHYS, va_reg, 32'd0, 1'b1};
                    end
                end else begin
                    ch_next = ch_reg + 3'd1;
                    if (ch_reg == 3'd7) begin
                        wa_next = wa_reg + 1'b1;
                    end
                end
            end
            ST_WR: begin
                ram_we    = 1'b1;
                ram_wdata = (mode_reg == MODE_VMARK) ? (buf_reg | mask) : (buf_reg & ~mask);
                wa_next   = wa_reg + 1'b1;
                if (!more && mode_reg == MODE_VMARK) begin
                    mode_next = MODE_PSCAN;
                    phys_next = 1'b1;
                    wa_next   = '0;
                    ch_next   = 3'd0;
                    run_next  = 7'd0;
                    len_next  = 7'd1;
                    page_next = 7'd0;
                    va_next   = va_reg + (32'(lo_reg) << PS);
                end
            end
            ST_PSET: begin
                ram_we    = 1'b1;
                ram_wdata = buf_reg | (WORD_BITS'(1) << lo_reg[WS-1:0]);
                pend_next = '{STAT_MAP, va_reg, pbase_reg + (32'(lo_reg) << PS),
                              (page_reg + 7'd1 == count_reg)};
            end
            ST_EMIT: begin
                if (room) begin
                    m_valid_next = 1'b1;
                    m_item_next  = pend_reg;
                    page_next    = page_reg + 7'd1;
                    va_next      = va_reg + 32'(PAGE_BYTES);
                    ch_next      = 3'd0;
                    run_next     = 7'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        user_reg   <= user_next;
        phys_reg   <= phys_next;
        count_reg  <= count_next;
        len_reg    <= len_next;
        run_reg    <= run_next;
        page_reg   <= page_next;
        size_reg   <= size_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        wa_reg     <= wa_next;
        ch_reg     <= ch_next;
        buf_reg    <= buf_next;
        va_reg     <= va_next;
        pbase_reg  <= pbase_next;
        pend_reg   <= pend_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_item        = m_item_reg;
    assign stat.clearing = (state_reg == ST_CLEAR);
    assign stat.idle     = (state_reg == ST_IDLE);
endmodule
